// File: sv/orbit_position_generator_defines.svh
// assertion macros for the orbit position generator
// no dependencies; included by the top level
`ifndef ORBIT_POSITION_GENERATOR_DEFINES_SVH
`define ORBIT_POSITION_GENERATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define OPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OPG_ASSERT_IMP(lbl, ante, cons, msg)
`define OPG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/opg_pkg.sv
// shared types, constants and tables of the orbit position generator
// no dependencies; used by the controller, datapath and top level
package opg_pkg;

    localparam int PHASE_W = 25;
    localparam int ANG_W   = 27;
    localparam int VAL_W   = 36;
    localparam int ACC_W   = 72;
    localparam int Z_W     = 29;

    localparam logic [PHASE_W-1:0] DEG360 = 25'd23592960;
    localparam logic [PHASE_W-1:0] DEG270 = 25'd17694720;
    localparam logic [PHASE_W-1:0] DEG180 = 25'd11796480;
    localparam logic [PHASE_W-1:0] DEG90  = 25'd5898240;
    localparam logic signed [VAL_W-1:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic [4:0] LAST_ITER = 5'd23;

    // operand and destination codes of the multiply sequence
    localparam logic [4:0] R_SH  = 5'd0;
    localparam logic [4:0] R_SP  = 5'd1;
    localparam logic [4:0] R_CH  = 5'd2;
    localparam logic [4:0] R_CB  = 5'd3;
    localparam logic [4:0] R_CP  = 5'd4;
    localparam logic [4:0] R_SB  = 5'd5;
    localparam logic [4:0] R_T1  = 5'd6;
    localparam logic [4:0] R_T2  = 5'd7;
    localparam logic [4:0] R_RAD = 5'd8;
    localparam logic [4:0] R_CO  = 5'd9;
    localparam logic [4:0] R_SO  = 5'd10;
    localparam logic [4:0] R_M00 = 5'd11;
    localparam logic [4:0] R_M20 = 5'd12;
    localparam logic [4:0] R_M01 = 5'd13;
    localparam logic [4:0] R_NSP = 5'd14;
    localparam logic [4:0] R_M02 = 5'd15;
    localparam logic [4:0] R_M22 = 5'd16;
    localparam logic [4:0] R_VX  = 5'd17;
    localparam logic [4:0] R_VZ  = 5'd18;
    localparam logic [4:0] R_RX  = 5'd19;
    localparam logic [4:0] R_RY  = 5'd20;
    localparam logic [4:0] R_RZ  = 5'd21;

    localparam logic [1:0] WB_SET = 2'd0;
    localparam logic [1:0] WB_ADD = 2'd1;
    localparam logic [1:0] WB_NEG = 2'd2;

    localparam logic [4:0] LAST_OP = 5'd16;

    typedef struct packed {
        logic [30:0]        orbit_radius;
        logic [24:0]        orbit_speed;
        logic [24:0]        spin_speed;
        logic signed [25:0] tilt_pitch;
        logic signed [25:0] tilt_yaw;
        logic signed [25:0] tilt_roll;
    } cfg_t;

    typedef struct packed {
        logic       latch_in;
        logic       advance;
        logic       load_ang;
        logic [1:0] ang_sel;
        logic       red_step;
        logic       cordic_init;
        logic       cordic_step;
        logic [4:0] iter;
        logic       trig_store;
        logic       mul_lo;
        logic       mul_hi;
        logic       mul_wb;
        logic [4:0] op;
        logic       result_load;
    } ctl_t;

    typedef struct packed {
        logic ang_ok;
    } sta_t;

    typedef struct packed {
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [4:0] dst;
        logic [1:0] mode;
    } op_t;

    // arctangent of 2^-i in units of 2^-20 degree
    function automatic logic [26:0] atan_q20(input logic [4:0] i);
        logic [26:0] v;
        case (i)
            5'd0:  v = 27'd47185920;
            5'd1:  v = 27'd27855475;
            5'd2:  v = 27'd14718068;
            5'd3:  v = 27'd7471121;
            5'd4:  v = 27'd3750058;
            5'd5:  v = 27'd1876857;
            5'd6:  v = 27'd938658;
            5'd7:  v = 27'd469357;
            5'd8:  v = 27'd234682;
            5'd9:  v = 27'd117342;
            5'd10: v = 27'd58671;
            5'd11: v = 27'd29335;
            5'd12: v = 27'd14668;
            5'd13: v = 27'd7334;
            5'd14: v = 27'd3667;
            5'd15: v = 27'd1833;
            5'd16: v = 27'd917;
            5'd17: v = 27'd458;
            5'd18: v = 27'd229;
            5'd19: v = 27'd115;
            5'd20: v = 27'd57;
            5'd21: v = 27'd29;
            5'd22: v = 27'd14;
            5'd23: v = 27'd7;
            default: v = 27'd0;
        endcase
        return v;
    endfunction

    // tilt matrix, circle point and rotation as a list of rounded products
    function automatic op_t op_info(input logic [4:0] op);
        op_t o;
        case (op)
            5'd0:  o = '{R_SH,  R_SP, R_T1,  WB_SET};
            5'd1:  o = '{R_CH,  R_CB, R_M00, WB_SET};
            5'd2:  o = '{R_T1,  R_SB, R_M00, WB_ADD};
            5'd3:  o = '{R_SH,  R_CP, R_M20, WB_SET};
            5'd4:  o = '{R_SB,  R_CP, R_M01, WB_SET};
            5'd5:  o = '{R_CH,  R_SP, R_T2,  WB_SET};
            5'd6:  o = '{R_SH,  R_CB, R_M02, WB_NEG};
            5'd7:  o = '{R_T2,  R_SB, R_M02, WB_ADD};
            5'd8:  o = '{R_CH,  R_CP, R_M22, WB_SET};
            5'd9:  o = '{R_RAD, R_CO, R_VX,  WB_SET};
            5'd10: o = '{R_RAD, R_SO, R_VZ,  WB_SET};
            5'd11: o = '{R_M00, R_VX, R_RX,  WB_SET};
            5'd12: o = '{R_M20, R_VZ, R_RX,  WB_ADD};
            5'd13: o = '{R_M01, R_VX, R_RY,  WB_SET};
            5'd14: o = '{R_NSP, R_VZ, R_RY,  WB_ADD};
            5'd15: o = '{R_M02, R_VX, R_RZ,  WB_SET};
            5'd16: o = '{R_M22, R_VZ, R_RZ,  WB_ADD};
            default: o = '{R_SH, R_SP, R_T1, WB_SET};
        endcase
        return o;
    endfunction

endpackage

// File: sv/orbit_position_generator.sv
// top level of the orbit position generator: register port, stream ports,
// controller and datapath; uses opg_pkg, opg_ctrl, opg_datapath and the defines header
//
//  channel | dir | handshake         | contents
//  s_axis  | in  | s_tvalid/s_tready | step time and parent position, one word per tick
//  m_axis  | out | m_tvalid/m_tready | position and spin angle, one word per tick
//  apb     | in  | psel/penable      | six configuration registers at 4*i
//
// an item runs from one accept to the next through one phase update, four trig
// evaluations on the shared cordic (each an angle load, reduction by 360, 24 rotation
// steps and a store), then 17 rounded products on the shared multiplier, a result load
// that waits while the output register still holds an unsent word, and one idle state.
// a new word is taken once the previous one has reached the output register,
// which holds it until m_tready; reset clears the phases, registers and valid.
`include "orbit_position_generator_defines.svh"
module orbit_position_generator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // step_time[15:0], parent_x[47:16], parent_y[79:48], parent_z[111:80]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], spin_out[120:96], zero fill
    output logic [127:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_OSPEED = 3'd1;
    localparam logic [2:0] REG_SSPEED = 3'd2;
    localparam logic [2:0] REG_PITCH  = 3'd3;
    localparam logic [2:0] REG_YAW    = 3'd4;
    localparam logic [2:0] REG_ROLL   = 3'd5;

    opg_pkg::cfg_t cfg_reg;
    opg_pkg::ctl_t ctl;
    opg_pkg::sta_t sta;
    logic          wr_en;
    logic [2:0]    reg_idx;

    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [24:0]        spin_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RADIUS: cfg_reg.orbit_radius <= pwdata[30:0];
                REG_OSPEED: cfg_reg.orbit_speed  <= pwdata[24:0];
                REG_SSPEED: cfg_reg.spin_speed   <= pwdata[24:0];
                REG_PITCH:  cfg_reg.tilt_pitch   <= pwdata[25:0];
                REG_YAW:    cfg_reg.tilt_yaw     <= pwdata[25:0];
                REG_ROLL:   cfg_reg.tilt_roll    <= pwdata[25:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RADIUS: prdata = {1'b0, cfg_reg.orbit_radius};
            REG_OSPEED: prdata = {7'b0, cfg_reg.orbit_speed};
            REG_SSPEED: prdata = {7'b0, cfg_reg.spin_speed};
            REG_PITCH:  prdata = {6'b0, cfg_reg.tilt_pitch};
            REG_YAW:    prdata = {6'b0, cfg_reg.tilt_yaw};
            REG_ROLL:   prdata = {6'b0, cfg_reg.tilt_roll};
            default:    prdata = '0;
        endcase
    end

    opg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sta      (sta),
        .ctl      (ctl)
    );

    opg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctl       (ctl),
        .sta       (sta),
        .step_time (s_tdata[15:0]),
        .parent_x  (s_tdata[47:16]),
        .parent_y  (s_tdata[79:48]),
        .parent_z  (s_tdata[111:80]),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .spin_out  (spin_out)
    );

    assign m_tdata = {7'b0, spin_out, pos_z, pos_y, pos_x};

    `OPG_ASSERT_IMP(a_load_free, ctl.result_load, !m_tvalid || m_tready, "result over unsent word")
    `OPG_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted word not held")
    `OPG_ASSERT_IMP(a_load_only_idle, ctl.latch_in, s_tready, "input latched while busy")

endmodule

// File: sv/opg_ctrl.sv
// sequencer of the orbit position generator: phase update, four trig
// evaluations, product list, result handoff; uses opg_pkg
module opg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  opg_pkg::sta_t sta,
    output opg_pkg::ctl_t ctl
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADV   = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_RED   = 4'd3;
    localparam logic [3:0] S_ROT   = 4'd4;
    localparam logic [3:0] S_STORE = 4'd5;
    localparam logic [3:0] S_MUL0  = 4'd6;
    localparam logic [3:0] S_MUL1  = 4'd7;
    localparam logic [3:0] S_MUL2  = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] ang_reg, ang_next;
    logic [4:0] iter_reg, iter_next;
    logic [4:0] op_reg, op_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ang_next   = ang_reg;
        iter_next  = iter_reg;
        op_next    = op_reg;
        ctl        = '0;
        ctl.ang_sel = ang_reg;
        ctl.iter    = iter_reg;
        ctl.op      = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = S_ADV;
                end
            end
            S_ADV:
            begin
                ctl.advance = 1'b1;
                ang_next    = 2'd0;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                ctl.load_ang = 1'b1;
                state_next   = S_RED;
            end
            S_RED:
            begin
                if (sta.ang_ok)
                begin
                    ctl.cordic_init = 1'b1;
                    iter_next       = 5'd0;
                    state_next      = S_ROT;
                end
                else
                begin
                    ctl.red_step = 1'b1;
                end
            end
            S_ROT:
            begin
                ctl.cordic_step = 1'b1;
                iter_next       = iter_reg + 5'd1;
                if (iter_reg == opg_pkg::LAST_ITER)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                ctl.trig_store = 1'b1;
                if (ang_reg == 2'd3)
                begin
                    op_next    = 5'd0;
                    state_next = S_MUL0;
                end
                else
                begin
                    ang_next   = ang_reg + 2'd1;
                    state_next = S_LOAD;
                end
            end
            S_MUL0:
            begin
                ctl.mul_lo = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                ctl.mul_hi = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                ctl.mul_wb = 1'b1;
                op_next    = op_reg + 5'd1;
                state_next = (op_reg == opg_pkg::LAST_OP) ? S_SUM : S_MUL0;
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    ctl.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.result_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ang_reg   <= 2'd0;
            iter_reg  <= 5'd0;
            op_reg    <= 5'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ang_reg   <= ang_next;
            iter_reg  <= iter_next;
            op_reg    <= op_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: sv/opg_datapath.sv
// phase accumulators, shared cordic, shared split multiplier and result
// registers of the orbit position generator; uses opg_pkg
module opg_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  opg_pkg::cfg_t       cfg,
    input  opg_pkg::ctl_t       ctl,
    output opg_pkg::sta_t       sta,
    input  logic [15:0]         step_time,
    input  logic signed [31:0]  parent_x,
    input  logic signed [31:0]  parent_y,
    input  logic signed [31:0]  parent_z,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic [24:0]         spin_out
);

    localparam int VW = opg_pkg::VAL_W;

    logic [24:0]          orbit_phase_reg, spin_phase_reg;
    logic [15:0]          dt_reg;
    logic signed [31:0]   px_reg, py_reg, pz_reg;

    logic signed [26:0]   a_reg;
    logic [1:0]           q_reg;
    logic signed [VW-1:0] x_reg, y_reg;
    logic signed [28:0]   z_reg;

    logic signed [VW-1:0] co_reg, so_reg, ch_reg, sh_reg;
    logic signed [VW-1:0] cp_reg, sp_reg, cb_reg, sb_reg;
    logic signed [VW-1:0] t1_reg, t2_reg, m00_reg, m20_reg, m01_reg, m02_reg, m22_reg;
    logic signed [VW-1:0] vx_reg, vz_reg, rx_reg, ry_reg, rz_reg;
    logic signed [opg_pkg::ACC_W-1:0] acc_reg;

    logic signed [31:0]   outx_reg, outy_reg, outz_reg;
    logic [24:0]          outs_reg;

    // ---------------- phase update
    function automatic logic [24:0] advance(input logic [24:0] ph, input logic [24:0] spd,
                                            input logic [15:0] dt);
        logic [40:0] prod;
        logic [25:0] p;
        prod = spd * dt;
        p = {1'b0, ph} + {1'b0, prod[40:16]};
        if (p > {1'b0, opg_pkg::DEG360})
        begin
            p = p - {1'b0, opg_pkg::DEG360};
        end
        return p[24:0];
    endfunction

    // ---------------- angle reduction and quadrant split
    logic signed [26:0] deg360_s;
    logic signed [26:0] ang_sel_val;
    logic [24:0]        a_u;
    logic [1:0]         q_val;
    logic [24:0]        rem_val;

    assign deg360_s = $signed({2'b00, opg_pkg::DEG360});
    assign sta.ang_ok = !a_reg[26] && (a_reg < deg360_s);
    assign a_u = a_reg[24:0];

    always_comb
    begin
        case (ctl.ang_sel)
            2'd0:    ang_sel_val = $signed({2'b00, orbit_phase_reg});
            2'd1:    ang_sel_val = 27'(cfg.tilt_yaw);
            2'd2:    ang_sel_val = 27'(cfg.tilt_pitch);
            default: ang_sel_val = 27'(cfg.tilt_roll);
        endcase
        if (a_u >= opg_pkg::DEG270)
        begin
            q_val   = 2'd3;
            rem_val = a_u - opg_pkg::DEG270;
        end
        else if (a_u >= opg_pkg::DEG180)
        begin
            q_val   = 2'd2;
            rem_val = a_u - opg_pkg::DEG180;
        end
        else if (a_u >= opg_pkg::DEG90)
        begin
            q_val   = 2'd1;
            rem_val = a_u - opg_pkg::DEG90;
        end
        else
        begin
            q_val   = 2'd0;
            rem_val = a_u;
        end
    end

    // ---------------- cordic iteration
    logic signed [VW-1:0] dx, dy;
    logic signed [28:0]   atan_s;
    logic signed [VW-1:0] cr, sr;

    assign dx     = y_reg >>> ctl.iter;
    assign dy     = x_reg >>> ctl.iter;
    assign atan_s = $signed({2'b00, opg_pkg::atan_q20(ctl.iter)});

    always_comb
    begin
        case (q_reg)
            2'd0:
            begin
                cr = x_reg;
                sr = y_reg;
            end
            2'd1:
            begin
                cr = -y_reg;
                sr = x_reg;
            end
            2'd2:
            begin
                cr = -x_reg;
                sr = -y_reg;
            end
            default:
            begin
                cr = y_reg;
                sr = -x_reg;
            end
        endcase
    end

    // ---------------- shared multiplier
    function automatic logic signed [VW-1:0] pick(
        input logic [4:0] code,
        input logic signed [VW-1:0] sh, sp, ch, cb, cp, sb, t1, t2, rad, co, so,
        input logic signed [VW-1:0] m00, m20, m01, m02, m22, vx, vz, rx, ry, rz);
        logic signed [VW-1:0] v;
        case (code)
            opg_pkg::R_SH:  v = sh;
            opg_pkg::R_SP:  v = sp;
            opg_pkg::R_CH:  v = ch;
            opg_pkg::R_CB:  v = cb;
            opg_pkg::R_CP:  v = cp;
            opg_pkg::R_SB:  v = sb;
            opg_pkg::R_T1:  v = t1;
            opg_pkg::R_T2:  v = t2;
            opg_pkg::R_RAD: v = rad;
            opg_pkg::R_CO:  v = co;
            opg_pkg::R_SO:  v = so;
            opg_pkg::R_M00: v = m00;
            opg_pkg::R_M20: v = m20;
            opg_pkg::R_M01: v = m01;
            opg_pkg::R_NSP: v = -sp;
            opg_pkg::R_M02: v = m02;
            opg_pkg::R_M22: v = m22;
            opg_pkg::R_VX:  v = vx;
            opg_pkg::R_VZ:  v = vz;
            opg_pkg::R_RX:  v = rx;
            opg_pkg::R_RY:  v = ry;
            opg_pkg::R_RZ:  v = rz;
            default:        v = '0;
        endcase
        return v;
    endfunction

    opg_pkg::op_t         op;
    logic signed [VW-1:0] rad_s, opa, opb, cur_dst, rnd, wb_val;
    logic signed [18:0]   b_lo;
    logic signed [17:0]   b_hi;
    logic signed [54:0]   p_lo;
    logic signed [53:0]   p_hi;
    logic signed [opg_pkg::ACC_W-1:0] acc_hi, acc_rnd;

    assign op    = opg_pkg::op_info(ctl.op);
    assign rad_s = $signed({5'b0, cfg.orbit_radius});
    assign opa   = pick(op.src_a, sh_reg, sp_reg, ch_reg, cb_reg, cp_reg, sb_reg, t1_reg,
                        t2_reg, rad_s, co_reg, so_reg, m00_reg, m20_reg, m01_reg, m02_reg,
                        m22_reg, vx_reg, vz_reg, rx_reg, ry_reg, rz_reg);
    assign opb   = pick(op.src_b, sh_reg, sp_reg, ch_reg, cb_reg, cp_reg, sb_reg, t1_reg,
                        t2_reg, rad_s, co_reg, so_reg, m00_reg, m20_reg, m01_reg, m02_reg,
                        m22_reg, vx_reg, vz_reg, rx_reg, ry_reg, rz_reg);
    assign cur_dst = pick(op.dst, sh_reg, sp_reg, ch_reg, cb_reg, cp_reg, sb_reg, t1_reg,
                          t2_reg, rad_s, co_reg, so_reg, m00_reg, m20_reg, m01_reg, m02_reg,
                          m22_reg, vx_reg, vz_reg, rx_reg, ry_reg, rz_reg);

    // low half unsigned, high half signed
    assign b_lo   = $signed({1'b0, opb[17:0]});
    assign b_hi   = opb[35:18];
    assign p_lo   = opa * b_lo;
    assign p_hi   = opa * b_hi;
    assign acc_hi = acc_reg + ({{(opg_pkg::ACC_W-54){p_hi[53]}}, p_hi} <<< 18);
    // round to nearest, ties upward
    assign acc_rnd = acc_reg + 72'sd536870912;
    assign rnd     = acc_rnd[65:30];

    always_comb
    begin
        case (op.mode)
            opg_pkg::WB_ADD: wb_val = cur_dst + rnd;
            opg_pkg::WB_NEG: wb_val = -rnd;
            default:         wb_val = rnd;
        endcase
    end

    // ---------------- saturating sum with parent
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                    input logic signed [VW-1:0] r);
        logic signed [VW:0] s;
        s = VW'(p) + r;
        if (s > 37'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (s < -37'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    // ---------------- state that reset clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orbit_phase_reg <= '0;
            spin_phase_reg  <= '0;
        end
        else if (ctl.advance)
        begin
            orbit_phase_reg <= advance(orbit_phase_reg, cfg.orbit_speed, dt_reg);
            spin_phase_reg  <= advance(spin_phase_reg, cfg.spin_speed, dt_reg);
        end
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            dt_reg <= step_time;
            px_reg <= parent_x;
            py_reg <= parent_y;
            pz_reg <= parent_z;
        end
        if (ctl.load_ang)
        begin
            a_reg <= ang_sel_val;
        end
        else if (ctl.red_step)
        begin
            a_reg <= a_reg[26] ? a_reg + deg360_s : a_reg - deg360_s;
        end
        if (ctl.cordic_init)
        begin
            q_reg <= q_val;
            x_reg <= opg_pkg::CORDIC_GAIN;
            y_reg <= '0;
            // remainder in units of 2^-20 degree
            z_reg <= $signed({rem_val, 4'b0000});
        end
        else if (ctl.cordic_step)
        begin
            if (!z_reg[28])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_s;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_s;
            end
        end
        if (ctl.trig_store)
        begin
            case (ctl.ang_sel)
                2'd0:
                begin
                    co_reg <= cr;
                    so_reg <= sr;
                end
                2'd1:
                begin
                    ch_reg <= cr;
                    sh_reg <= sr;
                end
                2'd2:
                begin
                    cp_reg <= cr;
                    sp_reg <= sr;
                end
                default:
                begin
                    cb_reg <= cr;
                    sb_reg <= sr;
                end
            endcase
        end
        if (ctl.mul_lo)
        begin
            acc_reg <= {{(opg_pkg::ACC_W-55){p_lo[54]}}, p_lo};
        end
        else if (ctl.mul_hi)
        begin
            acc_reg <= acc_hi;
        end
        if (ctl.mul_wb)
        begin
            case (op.dst)
                opg_pkg::R_T1:  t1_reg  <= wb_val;
                opg_pkg::R_T2:  t2_reg  <= wb_val;
                opg_pkg::R_M00: m00_reg <= wb_val;
                opg_pkg::R_M20: m20_reg <= wb_val;
                opg_pkg::R_M01: m01_reg <= wb_val;
                opg_pkg::R_M02: m02_reg <= wb_val;
                opg_pkg::R_M22: m22_reg <= wb_val;
                opg_pkg::R_VX:  vx_reg  <= wb_val;
                opg_pkg::R_VZ:  vz_reg  <= wb_val;
                opg_pkg::R_RX:  rx_reg  <= wb_val;
                opg_pkg::R_RY:  ry_reg  <= wb_val;
                opg_pkg::R_RZ:  rz_reg  <= wb_val;
                default:        t1_reg  <= t1_reg;
            endcase
        end
        if (ctl.result_load)
        begin
            outx_reg <= sat_add(px_reg, rx_reg);
            outy_reg <= sat_add(py_reg, ry_reg);
            outz_reg <= sat_add(pz_reg, rz_reg);
            outs_reg <= spin_phase_reg;
        end
    end

    assign pos_x    = outx_reg;
    assign pos_y    = outy_reg;
    assign pos_z    = outz_reg;
    assign spin_out = outs_reg;

endmodule

// File: tb/sv/tb.sv
// testbench of the orbit position generator: directed and random ticks checked
// against a fixed-point predictor of phases, cordic trig and tilted orbit; uses opg_pkg
`timescale 1ns / 100ps
module tb;

    localparam int MAX_CYCLES = 2000000;
    localparam logic [4:0] A_RADIUS = 5'd0;
    localparam logic [4:0] A_OSPEED = 5'd4;
    localparam logic [4:0] A_SSPEED = 5'd8;
    localparam logic [4:0] A_PITCH  = 5'd12;
    localparam logic [4:0] A_YAW    = 5'd16;
    localparam logic [4:0] A_ROLL   = 5'd20;
    localparam longint FULL_TURN = 64'd23592960;
    localparam longint QUARTER   = 64'd5898240;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [24:0] spin;
    } place_t;

    place_t         expected_places[$];
    opg_pkg::cfg_t  shadow;
    logic [24:0]    orbit_ang;
    logic [24:0]    spin_ang;
    int             mismatches;
    int             words_checked;
    int             cycles;
    bit             idle_src;
    bit             idle_sink;
    bit             hold_sink;
    int             hold_cycles;

    orbit_position_generator dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_shr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    task automatic sin_cos(input longint ang, output longint c, output longint s);
        longint x, y, z, q, r, dx, dy;
        x = 64'sd652032874;
        y = 0;
        while (ang < 0)
            ang += FULL_TURN;
        while (ang >= FULL_TURN)
            ang -= FULL_TURN;
        q = ang / QUARTER;
        r = ang - q * QUARTER;
        z = r * 16;
        for (int i = 0; i < 24; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(opg_pkg::atan_q20(5'(i)));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(opg_pkg::atan_q20(5'(i)));
            end
        end
        case (q)
            0: begin c = x; s = y; end
            1: begin c = -y; s = x; end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic [24:0] step_phase(logic [24:0] ph, logic [24:0] spd,
                                               logic [15:0] dt);
        longint p;
        p = longint'(ph) + ((longint'(spd) * longint'(dt)) >>> 16);
        if (p > FULL_TURN)
            p -= FULL_TURN;
        return p[24:0];
    endfunction

    function automatic logic [31:0] clamp_sum(longint a, longint b);
        longint v;
        v = a + b;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic predict_place(input logic [111:0] w);
        longint co, so, ch, sh, cp, sp, cb, sb, vx, vz, rad;
        longint m00, m20, m01, m21, m02, m22;
        place_t p;
        orbit_ang = step_phase(orbit_ang, shadow.orbit_speed, w[15:0]);
        spin_ang = step_phase(spin_ang, shadow.spin_speed, w[15:0]);
        sin_cos(longint'(orbit_ang), co, so);
        sin_cos(longint'(shadow.tilt_yaw), ch, sh);
        sin_cos(longint'(shadow.tilt_pitch), cp, sp);
        sin_cos(longint'(shadow.tilt_roll), cb, sb);
        rad = longint'(shadow.orbit_radius);
        vx = qmul(rad, co);
        vz = qmul(rad, so);
        m00 = qmul(ch, cb) + qmul(qmul(sh, sp), sb);
        m20 = qmul(sh, cp);
        m01 = qmul(sb, cp);
        m21 = -sp;
        m02 = -qmul(sh, cb) + qmul(qmul(ch, sp), sb);
        m22 = qmul(ch, cp);
        p.x = clamp_sum(longint'($signed(w[47:16])), qmul(m00, vx) + qmul(m20, vz));
        p.y = clamp_sum(longint'($signed(w[79:48])), qmul(m01, vx) + qmul(m21, vz));
        p.z = clamp_sum(longint'($signed(w[111:80])), qmul(m02, vx) + qmul(m22, vz));
        p.spin = spin_ang;
        expected_places.push_back(p);
    endtask

    // setup and access cycle; the bus is released by the caller after the last write
    task automatic write_reg(input logic [4:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (addr)
            A_RADIUS: shadow.orbit_radius = data[30:0];
            A_OSPEED: shadow.orbit_speed = data[24:0];
            A_SSPEED: shadow.spin_speed = data[24:0];
            A_PITCH:  shadow.tilt_pitch = data[25:0];
            A_YAW:    shadow.tilt_yaw = data[25:0];
            A_ROLL:   shadow.tilt_roll = data[25:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_places.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_orbit(input logic [30:0] rad, input logic [24:0] os,
                             input logic [24:0] ss, input logic [25:0] pit,
                             input logic [25:0] yw, input logic [25:0] rl);
        wait_drained();
        write_reg(A_RADIUS, {1'b0, rad});
        write_reg(A_OSPEED, {7'b0, os});
        write_reg(A_SSPEED, {7'b0, ss});
        write_reg(A_PITCH, {{6{pit[25]}}, pit});
        write_reg(A_YAW, {{6{yw[25]}}, yw});
        write_reg(A_ROLL, {{6{rl[25]}}, rl});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one tick word; a gap may precede it while idling is on
    task automatic send_tick(input logic [15:0] dt, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz);
        if (idle_src && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pz, py, px, dt};
        predict_place({pz, py, px, dt});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] any_coord();
        case ($urandom_range(0, 4))
            0: return 32'h7fff_ffff - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [25:0] any_tilt();
        case ($urandom_range(0, 5))
            0: return 26'd23592960;
            1: return -26'sd23592960;
            2: return 26'($urandom);
            3: return 26'(QUARTER * $urandom_range(0, 3));
            default: return 26'($urandom_range(0, 47185920)) - 26'd23592960;
        endcase
    endfunction

    function automatic logic [30:0] any_radius();
        case ($urandom_range(0, 3))
            0: return 31'h7fff_ffff;
            1: return 31'($urandom_range(0, 65536 * 1000));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        set_orbit(31'd0, 25'd0, 25'd0, 26'd0, 26'd0, 26'd0);
        send_tick(16'h0000, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
        send_tick(16'hffff, 32'hffff_ffff, 32'h0001_0000, 32'h8000_0000);
        set_orbit(31'h7fff_ffff, 25'h1ff_ffff, 25'h1ff_ffff, 26'd23592960,
                  -26'sd23592960, 26'h1ff_ffff);
        send_tick(16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_tick(16'hffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_tick(16'h8000, 32'd0, 32'd0, 32'd0);
        send_tick(16'h0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    endtask

    task automatic test_full_turn();
        // 360 deg/s for half-second steps: phases land exactly on 360
        set_orbit(31'd100 << 16, 25'd23592960, 25'd23592960, 26'd0, 26'd0, 26'd0);
        repeat (4) send_tick(16'h8000, 32'd0, 32'd0, 32'd0);
        set_orbit(31'd100 << 16, 25'd23592960, 25'd11796480, 26'(QUARTER),
                  26'(-QUARTER), 26'd11796480);
        repeat (4) send_tick(16'h4000, 32'd0, 32'd0, 32'd0);
        set_orbit(31'd1000 << 16, 25'd0, 25'd0, 26'(QUARTER), 26'(QUARTER),
                  26'(QUARTER));
        send_tick(16'h0000, 32'd0, 32'd0, 32'd0);
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++)
        begin
            if (k % 60 == 0)
                set_orbit(any_radius(),
                          ($urandom_range(0, 9) == 0) ? 25'($urandom) :
                              25'($urandom_range(0, 23592960)),
                          ($urandom_range(0, 9) == 0) ? 25'($urandom) :
                              25'($urandom_range(0, 23592960)),
                          any_tilt(), any_tilt(), any_tilt());
            if (k == count - 150)
            begin
                idle_src = 1'b0;
                idle_sink = 1'b0;
            end
            send_tick(16'($urandom), any_coord(), any_coord(), any_coord());
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 1500;
        hold_sink = 1'b1;
        repeat (6) send_tick(16'($urandom), any_coord(), any_coord(), any_coord());
        wait_drained();
        repeat (3) send_tick(16'($urandom), any_coord(), any_coord(), any_coord());
    endtask

    // receiver side: random stalls and one long hold
    always @(posedge clk)
    begin
        if (hold_sink)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles <= 1)
                hold_sink <= 1'b0;
        end
        else
            m_tready <= !(idle_sink && $urandom_range(0, 2) == 0);
    end

    always @(posedge clk)
    begin
        place_t want;
        place_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x = m_tdata[31:0];
            got.y = m_tdata[63:32];
            got.z = m_tdata[95:64];
            got.spin = m_tdata[120:96];
            if (expected_places.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word x=%h y=%h z=%h spin=%h",
                             got.x, got.y, got.z, got.spin);
            end
            else
            begin
                want = expected_places.pop_front();
                words_checked++;
                if (want !== got)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d exp x=%h y=%h z=%h spin=%h got %h %h %h %h",
                                 words_checked, want.x, want.y, want.z, want.spin,
                                 got.x, got.y, got.z, got.spin);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        shadow = '0;
        orbit_ang = '0;
        spin_ang = '0;
        mismatches = 0;
        words_checked = 0;
        cycles = 0;
        idle_src = 1'b1;
        idle_sink = 1'b1;
        hold_sink = 1'b0;
        hold_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_full_turn();
        test_backpressure();
        test_random(1720);
        wait_drained();
        $display("checked %0d position words over extreme, full-turn and random orbits",
                 words_checked);
        $display("with tilt and radius extremes, stalls and one long output hold");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/opg_pkg.sv
sv/opg_ctrl.sv
sv/opg_datapath.sv
sv/orbit_position_generator.sv
tb/sv/tb.sv
